>>> rtl/core/searchable_stack_top_macros.svh
// Assertion macros for the searchable stack.
// Included by searchable_stack_top; no other dependencies.
`ifndef SEARCHABLE_STACK_TOP_MACROS_SVH
`define SEARCHABLE_STACK_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SSTACK_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("searchable stack check failed");
`define SSTACK_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("searchable stack check failed");
`else
`define SSTACK_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define SSTACK_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> rtl/core/sstack_pkg.sv
// Shared types and constants of the searchable stack.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps
package sstack_pkg;

   localparam int OPCODE_WIDTH = 3;
   localparam int VALUE_WIDTH  = 32;
   localparam int TOTAL_WIDTH  = 5;
   localparam int STATUS_WIDTH = 2;

   localparam logic [OPCODE_WIDTH-1:0] OP_PUSH     = 3'd0;
   localparam logic [OPCODE_WIDTH-1:0] OP_POP      = 3'd1;
   localparam logic [OPCODE_WIDTH-1:0] OP_TOP      = 3'd2;
   localparam logic [OPCODE_WIDTH-1:0] OP_CONTAINS = 3'd3;
   localparam logic [OPCODE_WIDTH-1:0] OP_REMOVE   = 3'd4;
   localparam logic [OPCODE_WIDTH-1:0] OP_SIZE     = 3'd5;

   localparam logic [STATUS_WIDTH-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0]  read_value;
      logic                    found;
      logic [TOTAL_WIDTH-1:0]  entry_total;
      logic [STATUS_WIDTH-1:0] status;
   } rsp_data_type;

endpackage

>>> rtl/core/sstack_req_if.sv
// Request channel of the searchable stack: valid, ready and the request fields.
// Depends on sstack_pkg.
`timescale 1ns / 1ps
interface sstack_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [sstack_pkg::OPCODE_WIDTH-1:0]  opcode;
   logic [sstack_pkg::VALUE_WIDTH-1:0]   item_value;

   modport source (output valid, output opcode, output item_value, input ready);
   modport sink (input valid, input opcode, input item_value, output ready);
endinterface

>>> rtl/core/sstack_rsp_if.sv
// Response channel of the searchable stack: valid, ready and the result fields.
// Depends on sstack_pkg.
`timescale 1ns / 1ps
interface sstack_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [sstack_pkg::VALUE_WIDTH-1:0]   read_value;
   logic                                 found;
   logic [sstack_pkg::TOTAL_WIDTH-1:0]   entry_total;
   logic [sstack_pkg::STATUS_WIDTH-1:0]  status;

   modport source (output valid, output read_value, output found,
                   output entry_total, output status, input ready);
   modport sink (input valid, input read_value, input found,
                 input entry_total, input status, output ready);
endinterface

>>> rtl/core/searchable_stack_top.sv
// Searchable LIFO stack: push, pop, top, contains, remove matching and size.
// Depends on sstack_pkg, sstack_req_if, sstack_rsp_if, sstack_ram and the macro header.
//
//   Port      Direction  Role
//   req_port  sink       one request transaction: opcode and item_value
//   rsp_port  source     one response transaction per request
//
// Push, size and unused opcodes pass from S_IDLE through S_EMIT to the response register;
// pop and top also pass through S_READ on a non-empty stack, contains and remove
// through S_SCAN on a non-empty stack, which reads the stored entries in turn.
// The search rate is set by the single RAM read port: one stored entry per cycle.
// Reset clears the entry count and the control state; the RAM is never cleared and needs no pass.
// A new request is accepted while the previous response waits in the output register;
// a stalled response only holds the next result back in its final state.
`timescale 1ns / 1ps
`include "searchable_stack_top_macros.svh"
module searchable_stack_top #(
   parameter int DEPTH      = 16,
   parameter int ITEM_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   sstack_req_if.sink  req_port,
   sstack_rsp_if.source rsp_port
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int W  = (ITEM_WIDTH < sstack_pkg::VALUE_WIDTH) ? ITEM_WIDTH
                                                             : sstack_pkg::VALUE_WIDTH;

   typedef enum logic [1:0] {S_IDLE, S_READ, S_SCAN, S_EMIT} state_type;

   state_type                         state_ff, state_in;
   logic [CW-1:0]                     count_ff, count_in;
   logic [CW-1:0]                     scan_ff, scan_in;
   logic [CW-1:0]                     wr_ff, wr_in;
   logic                              hit_ff, hit_in;
   logic [sstack_pkg::OPCODE_WIDTH-1:0] op_ff, op_in;
   logic [W-1:0]                      key_ff, key_in;
   sstack_pkg::rsp_data_type          res_ff, res_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   sstack_pkg::rsp_data_type          rsp_data_ff, rsp_data_in;

   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [W-1:0]  ram_wdata;
   logic [AW-1:0] ram_raddr;
   logic [W-1:0]  ram_rdata;

   logic          req_fire;
   logic [W-1:0]  req_key;
   logic [CW-1:0] top_index;
   logic          match;
   logic          last;
   logic [CW-1:0] kept_total;

   sstack_ram #(.WIDTH(W), .DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_port.ready = (state_ff == S_IDLE);
   assign req_fire       = req_port.valid && (state_ff == S_IDLE);
   assign req_key        = W'(req_port.item_value);
   assign top_index      = count_ff - CW'(1);
   assign match          = (ram_rdata == key_ff);
   assign last           = (scan_ff == top_index);
   assign kept_total     = match ? wr_ff : wr_ff + CW'(1);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      scan_in      = scan_ff;
      wr_in        = wr_ff;
      hit_in       = hit_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_waddr    = count_ff[AW-1:0];
      ram_wdata    = req_key;
      ram_raddr    = '0;

      if (rsp_valid_ff && rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_port.opcode == sstack_pkg::OP_POP ||
                req_port.opcode == sstack_pkg::OP_TOP) begin
               ram_raddr = top_index[AW-1:0];
            end
            if (req_fire) begin
               op_in  = req_port.opcode;
               key_in = req_key;
               res_in = '{read_value: '0, found: 1'b0,
                          entry_total: sstack_pkg::TOTAL_WIDTH'(count_ff),
                          status: sstack_pkg::ST_OK};
               state_in = S_EMIT;
               unique case (req_port.opcode)
                  sstack_pkg::OP_PUSH: begin
                     if (count_ff == CW'(DEPTH)) begin
                        res_in.status = sstack_pkg::ST_FULL;
                     end else begin
                        ram_we             = 1'b1;
                        count_in           = count_ff + CW'(1);
                        res_in.entry_total = sstack_pkg::TOTAL_WIDTH'(count_ff + CW'(1));
                     end
                  end
                  sstack_pkg::OP_POP, sstack_pkg::OP_TOP: begin
                     if (count_ff == '0) begin
                        res_in.status = sstack_pkg::ST_EMPTY;
                     end else begin
                        state_in = S_READ;
                     end
                  end
                  sstack_pkg::OP_CONTAINS, sstack_pkg::OP_REMOVE: begin
                     if (count_ff != '0) begin
                        scan_in  = '0;
                        wr_in    = '0;
                        hit_in   = 1'b0;
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_READ: begin
            res_in.read_value = sstack_pkg::VALUE_WIDTH'(ram_rdata);
            if (op_ff == sstack_pkg::OP_POP) begin
               count_in           = top_index;
               res_in.entry_total = sstack_pkg::TOTAL_WIDTH'(top_index);
            end
            state_in = S_EMIT;
         end
         S_SCAN: begin
            ram_raddr = AW'(scan_ff + CW'(1));
            if (op_ff == sstack_pkg::OP_CONTAINS) begin
               if (match || last) begin
                  res_in.found = match;
                  state_in     = S_EMIT;
               end else begin
                  scan_in = scan_ff + CW'(1);
               end
            end else begin
               if (!match) begin
                  ram_we    = 1'b1;
                  ram_waddr = wr_ff[AW-1:0];
                  ram_wdata = ram_rdata;
                  wr_in     = wr_ff + CW'(1);
               end
               hit_in = hit_ff | match;
               if (last) begin
                  count_in           = kept_total;
                  res_in.found       = hit_ff | match;
                  res_in.entry_total = sstack_pkg::TOTAL_WIDTH'(kept_total);
                  state_in           = S_EMIT;
               end else begin
                  scan_in = scan_ff + CW'(1);
               end
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_port.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         scan_ff      <= '0;
         wr_ff        <= '0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         scan_ff      <= scan_in;
         wr_ff        <= wr_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
         op_ff        <= op_in;
         key_ff       <= key_in;
         res_ff       <= res_in;
         rsp_data_ff  <= rsp_data_in;
      end
   end

   assign rsp_port.valid       = rsp_valid_ff;
   assign rsp_port.read_value  = rsp_data_ff.read_value;
   assign rsp_port.found       = rsp_data_ff.found;
   assign rsp_port.entry_total = rsp_data_ff.entry_total;
   assign rsp_port.status      = rsp_data_ff.status;

   `SSTACK_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(DEPTH))
   `SSTACK_ASSERT_IMP(a_scan_in_range, clock, reset, state_ff == S_SCAN, scan_ff < count_ff)
   `SSTACK_ASSERT_IMP(a_compact_behind, clock, reset, state_ff == S_SCAN, wr_ff <= scan_ff)
   `SSTACK_ASSERT_NXT(a_push_grows, clock, reset,
      req_fire && req_port.opcode == sstack_pkg::OP_PUSH && count_ff < CW'(DEPTH),
      count_ff == $past(count_ff) + CW'(1))

endmodule

>>> rtl/core/sstack_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module sstack_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
